FILE: sv/assert_macros.svh
// Assertion macros shared by the chirp tone generator RTL.
// Included by each module that carries concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/ctg_pkg.sv
// Types, constants and the quarter-wave sine table for the chirp tone generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package ctg_pkg;

   // Sine table geometry (power of two, 64 .. 65536 entries)
   localparam int SINE_ENTRIES    = 1024;
   localparam int SINE_BITS       = $clog2(SINE_ENTRIES);
   localparam int QUARTER_BITS    = SINE_BITS - 2;
   localparam int QUARTER_ENTRIES = SINE_ENTRIES / 4;

   localparam longint Q30_ONE = 64'sd1073741824;
   localparam longint C1      = 64'sd1686629713;
   localparam longint C3      = -64'sd693598668;
   localparam longint C5      = 64'sd85569306;
   localparam longint C7      = -64'sd5026995;
   localparam longint C9      = 64'sd172272;
   localparam longint Q15_MAX = 64'sd32767;

   // Queues between and after the two halves
   localparam int WORK_PTR_W = 2;
   localparam int WORK_DEPTH = 2 ** WORK_PTR_W;
   localparam int OUT_PTR_W  = 2;
   localparam int OUT_DEPTH  = 2 ** OUT_PTR_W;

   // Register file
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [30:0] INIT_INC_RESET  = 31'd179159228;
   localparam logic [31:0] INC_DEC_RESET   = 32'd82468;
   localparam logic [14:0] PEAK_AMP_RESET  = 15'd9000;
   localparam logic [30:0] ENV_DEC_RESET   = 31'd297290;
   localparam logic [15:0] SAMPLE_CNT_RESET = 16'd1984;

   typedef enum logic [2:0] {
      REG_INITIAL_INCREMENT   = 3'd0,
      REG_INCREMENT_DECREMENT = 3'd1,
      REG_PEAK_AMPLITUDE      = 3'd2,
      REG_ENVELOPE_DECREMENT  = 3'd3,
      REG_SAMPLE_COUNT        = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [30:0] initial_increment;
      logic [31:0] increment_decrement;
      logic [14:0] peak_amplitude;
      logic [30:0] envelope_decrement;
      logic [15:0] sample_count;
   } cfg_type;

   // One classified tick handed from front to back
   typedef struct packed {
      logic                 active;
      logic                 last;
      logic [SINE_BITS-1:0] phase_k;
      logic [30:0]          envelope;
   } work_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               last;
      logic               active;
   } result_type;

   typedef logic [14:0] quarter_table_type [0:QUARTER_ENTRIES];

   // Q15 magnitude of the first quarter wave, one entry per table step,
   // plus the entry at exactly a quarter turn.
   function automatic quarter_table_type build_sine_quarter();
      quarter_table_type tbl;
      longint x;
      longint x2;
      longint r;
      longint s;
      longint q15;
      for (int j = 0; j <= QUARTER_ENTRIES; j++) begin
         x  = longint'(j) <<< (30 - QUARTER_BITS);
         x2 = (x * x) / Q30_ONE;
         r  = C9;
         r  = C7 + (r * x2) / Q30_ONE;
         r  = C5 + (r * x2) / Q30_ONE;
         r  = C3 + (r * x2) / Q30_ONE;
         r  = C1 + (r * x2) / Q30_ONE;
         s  = (x * r) / Q30_ONE;
         if (s < 0) begin
            s = 0;
         end
         q15 = (s * Q15_MAX + (Q30_ONE / 2)) / Q30_ONE;
         if (q15 > Q15_MAX) begin
            q15 = Q15_MAX;
         end
         tbl[j] = q15[14:0];
      end
      return tbl;
   endfunction

   localparam quarter_table_type SINE_QUARTER = build_sine_quarter();

endpackage

`default_nettype wire

FILE: sv/ctg_csr.sv
// APB-style register file holding the five sound settings.
// Depends on ctg_pkg for register codes, widths and reset values.
`default_nettype none

module ctg_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [ctg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ctg_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [ctg_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready,
   output ctg_pkg::cfg_type                    cfg
);
   import ctg_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_sel;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign reg_sel    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_INITIAL_INCREMENT:   cfg_in.initial_increment   = csr_pwdata[30:0];
            REG_INCREMENT_DECREMENT: cfg_in.increment_decrement = csr_pwdata[31:0];
            REG_PEAK_AMPLITUDE:      cfg_in.peak_amplitude      = csr_pwdata[14:0];
            REG_ENVELOPE_DECREMENT:  cfg_in.envelope_decrement  = csr_pwdata[30:0];
            REG_SAMPLE_COUNT:        cfg_in.sample_count        = csr_pwdata[15:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_INITIAL_INCREMENT:   csr_prdata = {1'b0, cfg_ff.initial_increment};
         REG_INCREMENT_DECREMENT: csr_prdata = cfg_ff.increment_decrement;
         REG_PEAK_AMPLITUDE:      csr_prdata = {17'b0, cfg_ff.peak_amplitude};
         REG_ENVELOPE_DECREMENT:  csr_prdata = {1'b0, cfg_ff.envelope_decrement};
         REG_SAMPLE_COUNT:        csr_prdata = {16'b0, cfg_ff.sample_count};
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.initial_increment   <= INIT_INC_RESET;
         cfg_ff.increment_decrement <= INC_DEC_RESET;
         cfg_ff.peak_amplitude      <= PEAK_AMP_RESET;
         cfg_ff.envelope_decrement  <= ENV_DEC_RESET;
         cfg_ff.sample_count        <= SAMPLE_CNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/ctg_front.sv
// Front half: accepts ticks, runs the phase, step, envelope and index recurrences,
// and queues one work record per tick. Depends on ctg_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ctg_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctg_pkg::cfg_type  cfg,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic              req_restart,
   output logic                   work_valid,
   output ctg_pkg::work_type      work_head,
   input  wire logic              work_pop
);
   import ctg_pkg::*;

   logic [31:0] phase_ff, phase_in;
   logic [31:0] step_ff, step_in;
   logic [30:0] envelope_ff, envelope_in;
   logic [15:0] index_ff, index_in;
   logic        running_ff, running_in;

   work_type              queue_ff [WORK_DEPTH];
   logic [WORK_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [WORK_PTR_W:0]   count_ff, count_in;

   logic        accept;
   logic        do_pop;
   logic [31:0] cur_phase;
   logic [31:0] cur_step;
   logic [30:0] cur_env;
   logic [15:0] cur_index;
   logic        cur_run;
   logic        is_last;
   work_type    record;

   assign req_full   = (count_ff == (WORK_PTR_W+1)'(WORK_DEPTH));
   assign accept     = req_push & ~req_full;
   assign work_valid = (count_ff != '0);
   assign do_pop     = work_pop & work_valid;
   assign work_head  = queue_ff[rd_ptr_ff];

   // Restart loads the sound's settings; sample zero comes out on the same tick.
   always_comb begin
      cur_phase = req_restart ? 32'd0 : phase_ff;
      cur_step  = req_restart ? {1'b0, cfg.initial_increment} : step_ff;
      cur_env   = req_restart ? {cfg.peak_amplitude, 16'd0} : envelope_ff;
      cur_index = req_restart ? 16'd0 : index_ff;
      cur_run   = req_restart | running_ff;
      is_last   = (cur_index == (cfg.sample_count - 16'd1));

      record.active   = cur_run;
      record.last     = cur_run & is_last;
      record.phase_k  = cur_phase[31 -: SINE_BITS];
      // Zero envelope makes an idle tick come out as a zero sample.
      record.envelope = cur_run ? cur_env : 31'd0;

      phase_in    = phase_ff;
      step_in     = step_ff;
      envelope_in = envelope_ff;
      index_in    = index_ff;
      running_in  = running_ff;
      if (accept && cur_run) begin
         phase_in    = cur_phase + cur_step;
         step_in     = cur_step - cfg.increment_decrement;
         envelope_in = (cur_env > cfg.envelope_decrement) ?
                       (cur_env - cfg.envelope_decrement) : 31'd0;
         index_in    = cur_index + 16'd1;
         running_in  = ~is_last;
      end
   end

   always_comb begin
      case ({accept, do_pop})
         2'b10:   count_in = count_ff + (WORK_PTR_W+1)'(1);
         2'b01:   count_in = count_ff - (WORK_PTR_W+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= '0;
         step_ff     <= '0;
         envelope_ff <= '0;
         index_ff    <= '0;
         running_ff  <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         step_ff     <= step_in;
         envelope_ff <= envelope_in;
         index_ff    <= index_in;
         running_ff  <= running_in;
         count_ff    <= count_in;
         if (accept) begin
            wr_ptr_ff <= wr_ptr_ff + WORK_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + WORK_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= record;
      end
   end

   `ASSERT_ALWAYS(a_work_count_bound, clock, reset,
      count_ff <= (WORK_PTR_W+1)'(WORK_DEPTH), "work queue count beyond depth")
   `ASSERT_IMPLIES(a_stop_after_last, clock, reset, $fell(running_ff),
      $past(accept && record.last), "sound stopped without a final beat")

endmodule

`default_nettype wire

FILE: sv/ctg_back.sv
// Back half: sine lookup, envelope multiply, truncation toward zero and the result queue.
// Depends on ctg_pkg (sine table, record types) and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ctg_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              work_valid,
   input  wire ctg_pkg::work_type work_head,
   output logic                   work_pop,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output ctg_pkg::result_type    rsp_head
);
   import ctg_pkg::*;

   localparam int PEND_W = OUT_PTR_W + 2;

   // Lookup stage
   logic               a_valid_ff;
   logic signed [15:0] a_entry_ff;
   logic [30:0]        a_env_ff;
   logic               a_last_ff;
   logic               a_active_ff;
   // Multiply stage
   logic               b_valid_ff;
   logic signed [47:0] b_prod_ff;
   logic               b_last_ff;
   logic               b_active_ff;

   result_type           out_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] out_wr_ff, out_rd_ff;
   logic [OUT_PTR_W:0]   out_count_ff, out_count_in;

   logic [1:0]              quad;
   logic [QUARTER_BITS-1:0] quarter_pos;
   logic [QUARTER_BITS:0]   table_idx;
   logic [14:0]             magnitude;
   logic signed [15:0]      entry;
   logic signed [47:0]      prod_in;
   logic signed [47:0]      rounded;
   result_type              result;
   logic [PEND_W-1:0]       pending;
   logic                    do_pop;

   // Hold issue until the result queue has a slot for everything in flight.
   assign pending  = PEND_W'(out_count_ff) + PEND_W'(a_valid_ff) + PEND_W'(b_valid_ff);
   assign work_pop = work_valid && (pending < PEND_W'(OUT_DEPTH));

   // Fold into the first quarter wave; the second half-turn negates.
   assign quad        = work_head.phase_k[SINE_BITS-1 -: 2];
   assign quarter_pos = work_head.phase_k[QUARTER_BITS-1:0];
   assign table_idx   = quad[0] ?
                        ((QUARTER_BITS+1)'(QUARTER_ENTRIES) - {1'b0, quarter_pos}) :
                        {1'b0, quarter_pos};
   assign magnitude   = SINE_QUARTER[table_idx];
   assign entry       = quad[1] ? -$signed({1'b0, magnitude}) : $signed({1'b0, magnitude});

   assign prod_in = a_entry_ff * $signed({1'b0, a_env_ff});
   // Bias negatives so the shift truncates toward zero.
   assign rounded = b_prod_ff[47] ? (b_prod_ff + 48'sh0000_7FFF_FFFF) : b_prod_ff;

   always_comb begin
      result.sample = rounded[46:31];
      result.last   = b_last_ff;
      result.active = b_active_ff;
   end

   assign rsp_empty = (out_count_ff == '0);
   assign do_pop    = rsp_pop & ~rsp_empty;
   assign rsp_head  = out_ff[out_rd_ff];

   always_comb begin
      case ({b_valid_ff, do_pop})
         2'b10:   out_count_in = out_count_ff + (OUT_PTR_W+1)'(1);
         2'b01:   out_count_in = out_count_ff - (OUT_PTR_W+1)'(1);
         default: out_count_in = out_count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_count_ff <= '0;
      end else begin
         a_valid_ff   <= work_pop;
         b_valid_ff   <= a_valid_ff;
         out_count_ff <= out_count_in;
         if (b_valid_ff) begin
            out_wr_ff <= out_wr_ff + OUT_PTR_W'(1);
         end
         if (do_pop) begin
            out_rd_ff <= out_rd_ff + OUT_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      a_entry_ff  <= entry;
      a_env_ff    <= work_head.envelope;
      a_last_ff   <= work_head.last;
      a_active_ff <= work_head.active;
      b_prod_ff   <= prod_in;
      b_last_ff   <= a_last_ff;
      b_active_ff <= a_active_ff;
      if (b_valid_ff) begin
         out_ff[out_wr_ff] <= result;
      end
   end

   `ASSERT_ALWAYS(a_credit_bound, clock, reset,
      pending <= PEND_W'(OUT_DEPTH), "results in flight exceed queue room")
   `ASSERT_NEXT(a_stage_advance, clock, reset, a_valid_ff, b_valid_ff,
      "lookup beat lost before multiply")

endmodule

`default_nettype wire

FILE: sv/chirp_tone_generator_top.sv
// Chirp tone generator: one signed 16-bit sample per input beat.
// A result passes the front queue, the lookup and multiply registers, then the result queue.
// Throughput: one beat per cycle sustained while neither queue backs up; the front recurrences
// advance on each accepted beat, and the back issues only while the result queue has room.
// Reset (synchronous, active high): idle, queues empty, settings back to defaults.
`default_nettype none

module chirp_tone_generator_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic                           req_restart,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic signed [15:0]                  rsp_sample,
   output logic                                rsp_last,
   output logic                                rsp_active,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [ctg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ctg_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [ctg_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);
   import ctg_pkg::*;

   cfg_type    cfg;
   work_type   work_head;
   logic       work_valid;
   logic       work_pop;
   result_type rsp_head;

   ctg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ctg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_restart (req_restart),
      .work_valid  (work_valid),
      .work_head   (work_head),
      .work_pop    (work_pop)
   );

   ctg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (work_valid),
      .work_head  (work_head),
      .work_pop   (work_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_head   (rsp_head)
   );

   assign rsp_sample = rsp_head.sample;
   assign rsp_last   = rsp_head.last;
   assign rsp_active = rsp_head.active;

endmodule

`default_nettype wire

FILE: verif/ctg_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the chirp tone generator: mirrors the register file from APB beats,
// predicts every sample from request beats and checks each response beat in order.
// Depends on ctg_pkg for register indexes, the settings record and the result record.

module ctg_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  logic                           req_full,
   input  logic                           req_restart,
   input  logic                           rsp_empty,
   input  logic                           rsp_pop,
   input  logic signed [15:0]             rsp_sample,
   input  logic                           rsp_last,
   input  logic                           rsp_active,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ctg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   input  logic [31:0]                    csr_prdata,
   input  logic                           csr_pready,
   output int                             error_count,
   output int                             samples_owed
);

   localparam int LUT_SHIFT = 32 - ctg_pkg::SINE_BITS;

   ctg_pkg::cfg_type       settings;
   logic [31:0]            phase_acc;
   logic [31:0]            phase_step;
   logic [30:0]            envelope;
   logic [15:0]            sample_idx;
   logic                   sounding;
   int                     sine_lut [ctg_pkg::SINE_ENTRIES];
   ctg_pkg::result_type    samples_due [$];
   ctg_pkg::result_type    due;
   ctg_pkg::reg_index_type slot;
   logic [31:0]            image;
   logic                   mapped;

   // Q15 sine of an angle given as a 32-bit fraction of a turn, folded to a quarter wave
   function automatic int turn_to_q15(input logic [31:0] angle);
      longint frac;
      longint sq;
      longint acc;
      longint mag;
      frac = longint'(angle[29:0]);
      if (angle[30]) begin
         frac = ctg_pkg::Q30_ONE - frac;
      end
      sq  = (frac * frac) / ctg_pkg::Q30_ONE;
      acc = ctg_pkg::C9;
      acc = ctg_pkg::C7 + (acc * sq) / ctg_pkg::Q30_ONE;
      acc = ctg_pkg::C5 + (acc * sq) / ctg_pkg::Q30_ONE;
      acc = ctg_pkg::C3 + (acc * sq) / ctg_pkg::Q30_ONE;
      acc = ctg_pkg::C1 + (acc * sq) / ctg_pkg::Q30_ONE;
      mag = (frac * acc) / ctg_pkg::Q30_ONE;
      if (mag < 0) begin
         mag = 0;
      end
      mag = (mag * 32767 + ctg_pkg::Q30_ONE / 2) / ctg_pkg::Q30_ONE;
      if (mag > 32767) begin
         mag = 32767;
      end
      return angle[31] ? -int'(mag) : int'(mag);
   endfunction

   function automatic void restore_defaults();
      settings.initial_increment   = ctg_pkg::INIT_INC_RESET;
      settings.increment_decrement = ctg_pkg::INC_DEC_RESET;
      settings.peak_amplitude      = ctg_pkg::PEAK_AMP_RESET;
      settings.envelope_decrement  = ctg_pkg::ENV_DEC_RESET;
      settings.sample_count        = ctg_pkg::SAMPLE_CNT_RESET;
      phase_acc  = '0;
      phase_step = '0;
      envelope   = '0;
      sample_idx = '0;
      sounding   = 1'b0;
   endfunction

   // Advance the tone by one tick and return the sample it yields
   function automatic ctg_pkg::result_type next_sample(input logic restart);
      ctg_pkg::result_type r;
      longint              product;
      longint              scaled;
      logic                final_tick;
      if (restart) begin
         phase_acc  = '0;
         phase_step = {1'b0, settings.initial_increment};
         envelope   = {settings.peak_amplitude, 16'd0};
         sample_idx = '0;
         sounding   = 1'b1;
      end
      r = '0;
      if (sounding) begin
         product    = longint'(sine_lut[phase_acc[31:LUT_SHIFT]]) * longint'(envelope);
         scaled     = product / 64'sd2147483648;
         final_tick = (sample_idx == 16'(settings.sample_count - 16'd1));
         r.sample   = scaled[15:0];
         r.last     = final_tick;
         r.active   = 1'b1;
         phase_acc  = phase_acc + phase_step;
         phase_step = phase_step - settings.increment_decrement;
         envelope   = (envelope > settings.envelope_decrement) ?
                      envelope - settings.envelope_decrement : 31'd0;
         sample_idx = sample_idx + 16'd1;
         if (final_tick) begin
            sounding = 1'b0;
         end
      end
      return r;
   endfunction

   initial begin
      error_count  = 0;
      samples_owed = 0;
      for (int k = 0; k < ctg_pkg::SINE_ENTRIES; k++) begin
         sine_lut[k] = turn_to_q15(32'(k) << LUT_SHIFT);
      end
      restore_defaults();
   end

   always @(posedge clock) begin
      if (reset) begin
         restore_defaults();
         samples_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            slot = ctg_pkg::reg_index_type'(csr_paddr[ctg_pkg::CSR_ADDR_W-1:2]);
            if (csr_pwrite) begin
               case (slot)
                  ctg_pkg::REG_INITIAL_INCREMENT:
                     settings.initial_increment = csr_pwdata[30:0];
                  ctg_pkg::REG_INCREMENT_DECREMENT:
                     settings.increment_decrement = csr_pwdata;
                  ctg_pkg::REG_PEAK_AMPLITUDE:
                     settings.peak_amplitude = csr_pwdata[14:0];
                  ctg_pkg::REG_ENVELOPE_DECREMENT:
                     settings.envelope_decrement = csr_pwdata[30:0];
                  ctg_pkg::REG_SAMPLE_COUNT:
                     settings.sample_count = csr_pwdata[15:0];
                  default: ;
               endcase
            end else begin
               mapped = 1'b1;
               case (slot)
                  ctg_pkg::REG_INITIAL_INCREMENT:   image = {1'b0, settings.initial_increment};
                  ctg_pkg::REG_INCREMENT_DECREMENT: image = settings.increment_decrement;
                  ctg_pkg::REG_PEAK_AMPLITUDE:      image = {17'd0, settings.peak_amplitude};
                  ctg_pkg::REG_ENVELOPE_DECREMENT:  image = {1'b0, settings.envelope_decrement};
                  ctg_pkg::REG_SAMPLE_COUNT:        image = {16'd0, settings.sample_count};
                  default: begin
                     image  = '0;
                     mapped = 1'b0;
                  end
               endcase
               if (mapped && csr_prdata !== image) begin
                  $display("%0t: register %0d readback mismatch, expected 0x%08h, actual 0x%08h",
                           $time, slot, image, csr_prdata);
                  error_count++;
               end
            end
         end

         if (req_push && !req_full) begin
            samples_due.push_back(next_sample(req_restart));
         end

         if (rsp_pop && !rsp_empty) begin
            if (samples_due.size() == 0) begin
               $display("%0t: unexpected response beat, expected none, actual sample %0d",
                        $time, rsp_sample);
               error_count++;
            end else begin
               due = samples_due.pop_front();
               if (rsp_sample !== due.sample) begin
                  $display("%0t: sample mismatch, expected %0d, actual %0d",
                           $time, $signed(due.sample), rsp_sample);
                  error_count++;
               end
               if (rsp_last !== due.last) begin
                  $display("%0t: last mismatch, expected %0b, actual %0b",
                           $time, due.last, rsp_last);
                  error_count++;
               end
               if (rsp_active !== due.active) begin
                  $display("%0t: active mismatch, expected %0b, actual %0b",
                           $time, due.active, rsp_active);
                  error_count++;
               end
            end
         end
      end
      samples_owed = samples_due.size();
   end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Top of the chirp tone generator testbench: clock, reset, request/response and APB stimulus,
// watchdog and verdict. Depends on ctg_pkg, chirp_tone_generator_top and ctg_checker.

module tb_top;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_BEATS   = 950;
   localparam int TAIL_CYCLES    = 16;

   logic                           clock;
   logic                           reset;
   logic                           req_push;
   logic                           req_full;
   logic                           req_restart;
   logic                           rsp_empty;
   logic                           rsp_pop;
   logic signed [15:0]             rsp_sample;
   logic                           rsp_last;
   logic                           rsp_active;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [ctg_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]                    csr_pwdata;
   logic [31:0]                    csr_prdata;
   logic                           csr_pready;

   int          mismatches;
   int          samples_owed;
   int          beats_sent;
   int          stall_cycles;
   bit          calm;
   logic [15:0] sound_length;
   wire         any_beat = (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
                           (csr_psel && csr_penable && csr_pready);

   chirp_tone_generator_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_restart (req_restart),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_sample  (rsp_sample),
      .rsp_last    (rsp_last),
      .rsp_active  (rsp_active),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ctg_checker scoreboard (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_restart  (req_restart),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_sample   (rsp_sample),
      .rsp_last     (rsp_last),
      .rsp_active   (rsp_active),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .error_count  (mismatches),
      .samples_owed (samples_owed)
   );

   always #2 clock = ~clock;

   always @(negedge clock) begin
      rsp_pop <= calm || ($urandom_range(99) >= 16);
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_tick(input logic restart);
      while (!calm && $urandom_range(99) < 16) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push    <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
      beats_sent++;
   endtask

   // Hold requests until every predicted sample has been popped
   task automatic settle();
      req_push <= 1'b0;
      while (samples_owed != 0) @(negedge clock);
   endtask

   task automatic apb_beat(input logic is_write, input logic [ctg_pkg::CSR_ADDR_W-1:0] addr,
                           input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Write a register and read it back; the checker compares the readback
   task automatic program_reg(input ctg_pkg::reg_index_type idx, input logic [31:0] value);
      apb_beat(1'b1, {idx, 2'b00}, value);
      apb_beat(1'b0, {idx, 2'b00}, $urandom);
      if (idx == ctg_pkg::REG_SAMPLE_COUNT) begin
         sound_length = value[15:0];
      end
   endtask

   task automatic play_sound(input int ticks);
      send_tick(1'b1);
      repeat (ticks - 1) send_tick(1'b0);
   endtask

   function automatic logic [31:0] pick_word(input logic [31:0] mask);
      case ($urandom_range(7))
         0:       return '0;
         1:       return mask;
         2:       return (mask >> 1) + 32'd1;
         3:       return mask >> 1;
         default: return $urandom & mask;
      endcase
   endfunction

   function automatic logic [31:0] pick_length();
      case ($urandom_range(9))
         0:       return $urandom_range(25, 300);
         1:       return 32'd1;
         default: return $urandom_range(2, 24);
      endcase
   endfunction

   function automatic logic [31:0] pick_env_step();
      if ($urandom_range(1) == 0) begin
         return $urandom_range(0, 1 << 19);
      end
      return pick_word(32'h7FFF_FFFF);
   endfunction

   function automatic logic [31:0] pick_step_drop();
      if ($urandom_range(2) == 0) begin
         return $urandom_range(0, 400000) - 200000;
      end
      return pick_word(32'hFFFF_FFFF);
   endfunction

   task automatic shuffle_settings();
      if ($urandom_range(1)) program_reg(ctg_pkg::REG_INITIAL_INCREMENT, pick_word(32'h7FFF_FFFF));
      if ($urandom_range(1)) program_reg(ctg_pkg::REG_INCREMENT_DECREMENT, pick_step_drop());
      if ($urandom_range(1)) program_reg(ctg_pkg::REG_PEAK_AMPLITUDE, pick_word(32'h7FFF));
      if ($urandom_range(1)) program_reg(ctg_pkg::REG_ENVELOPE_DECREMENT, pick_env_step());
      if ($urandom_range(1)) program_reg(ctg_pkg::REG_SAMPLE_COUNT, pick_length());
   endtask

   initial begin
      stall_cycles = 0;
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (any_beat) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int          played;
      logic [31:0] stretched;
      clock        = 1'b0;
      reset        = 1'b1;
      req_push     = 1'b0;
      req_restart  = 1'b0;
      rsp_pop      = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      calm         = 1'b0;
      beats_sent   = 0;
      sound_length = ctg_pkg::SAMPLE_CNT_RESET;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // idle ticks out of reset, then the first samples of the default sound
      send_tick(1'b0);
      send_tick(1'b0);
      play_sound(3);
      settle();
      for (int i = 0; i < 5; i++) begin
         apb_beat(1'b0, ctg_pkg::CSR_ADDR_W'(i * 4), '0);
      end

      // one-sample sounds, start increment and peak at the top, no envelope decrement, back-to-back restarts
      program_reg(ctg_pkg::REG_INITIAL_INCREMENT, 32'h7FFF_FFFF);
      program_reg(ctg_pkg::REG_INCREMENT_DECREMENT, 32'h8000_0000);
      program_reg(ctg_pkg::REG_PEAK_AMPLITUDE, 32'h7FFF);
      program_reg(ctg_pkg::REG_ENVELOPE_DECREMENT, 32'd0);
      program_reg(ctg_pkg::REG_SAMPLE_COUNT, 32'd1);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      settle();

      // zero amplitude, largest decrements, restart in mid-sound
      program_reg(ctg_pkg::REG_INITIAL_INCREMENT, 32'd0);
      program_reg(ctg_pkg::REG_INCREMENT_DECREMENT, 32'h7FFF_FFFF);
      program_reg(ctg_pkg::REG_PEAK_AMPLITUDE, 32'd0);
      program_reg(ctg_pkg::REG_ENVELOPE_DECREMENT, 32'h7FFF_FFFF);
      program_reg(ctg_pkg::REG_SAMPLE_COUNT, 32'd3);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      repeat (3) send_tick(1'b0);
      settle();

      // envelope equal to its decrement clamps to zero; quarter-turn steps
      program_reg(ctg_pkg::REG_PEAK_AMPLITUDE, 32'd1);
      program_reg(ctg_pkg::REG_ENVELOPE_DECREMENT, 32'd65536);
      program_reg(ctg_pkg::REG_INITIAL_INCREMENT, 32'h4000_0000);
      program_reg(ctg_pkg::REG_INCREMENT_DECREMENT, 32'hFFFF_FFFF);
      program_reg(ctg_pkg::REG_SAMPLE_COUNT, 32'd8);
      apb_beat(1'b1, 5'd20, $urandom);
      play_sound(4);
      settle();

      // shorten the sound under way; start and peak wait for the next restart
      program_reg(ctg_pkg::REG_SAMPLE_COUNT, 32'd5);
      program_reg(ctg_pkg::REG_INCREMENT_DECREMENT, 32'd0);
      program_reg(ctg_pkg::REG_ENVELOPE_DECREMENT, 32'd0);
      program_reg(ctg_pkg::REG_INITIAL_INCREMENT, 32'd1234);
      program_reg(ctg_pkg::REG_PEAK_AMPLITUDE, 32'h7FFF);
      send_tick(1'b0);
      send_tick(1'b0);
      play_sound(5);
      settle();

      beats_sent = 0;
      while (beats_sent < RANDOM_BEATS) begin
         calm = (beats_sent >= 400 && beats_sent < 600);
         if ($urandom_range(2) == 0) begin
            settle();
            shuffle_settings();
            if ($urandom_range(15) == 0) begin
               apb_beat(1'b1, {3'($urandom_range(5, 7)), 2'b00}, $urandom);
            end
         end
         case ($urandom_range(9))
            0, 1: begin
               repeat ($urandom_range(1, 16)) send_tick($urandom_range(3) == 0);
            end
            2: begin
               // retune in mid-sound or just after it ends, then let it finish at an equal or longer count
               played = $urandom_range(1, sound_length);
               play_sound(played);
               settle();
               stretched = sound_length + $urandom_range(0, 8);
               if (stretched > 32'hFFFF) begin
                  stretched = 32'hFFFF;
               end
               program_reg(ctg_pkg::REG_SAMPLE_COUNT, stretched);
               program_reg(ctg_pkg::REG_INCREMENT_DECREMENT, pick_step_drop());
               program_reg(ctg_pkg::REG_ENVELOPE_DECREMENT, pick_env_step());
               program_reg(ctg_pkg::REG_INITIAL_INCREMENT, pick_word(32'h7FFF_FFFF));
               program_reg(ctg_pkg::REG_PEAK_AMPLITUDE, pick_word(32'h7FFF));
               repeat (int'(stretched) - played + 2) send_tick(1'b0);
            end
            default: begin
               play_sound(sound_length);
               repeat ($urandom_range(0, 2)) send_tick(1'b0);
            end
         endcase
      end
      calm = 1'b0;
      settle();

      // zero sample count: no final beat at index zero or at any small index
      program_reg(ctg_pkg::REG_INITIAL_INCREMENT, $urandom & 32'h7FFF_FFFF);
      program_reg(ctg_pkg::REG_INCREMENT_DECREMENT, $urandom_range(0, 4000) - 2000);
      program_reg(ctg_pkg::REG_PEAK_AMPLITUDE, $urandom & 32'h7FFF);
      program_reg(ctg_pkg::REG_ENVELOPE_DECREMENT, $urandom_range(0, 40000));
      program_reg(ctg_pkg::REG_SAMPLE_COUNT, 32'd0);
      play_sound(40);
      settle();

      // drop the count below the current index: the sound keeps going past it
      program_reg(ctg_pkg::REG_SAMPLE_COUNT, 32'd20);
      play_sound(10);
      settle();
      program_reg(ctg_pkg::REG_SAMPLE_COUNT, 32'd5);
      repeat (24) send_tick(1'b0);
      settle();

      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0 && samples_owed == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
